// ===== design/edfs_pkg.sv =====
// Shared types and constants for the EDF task scheduler.
// No dependencies.
package edfs_pkg;

  localparam int KIND_W = 3;
  localparam int TIME_W = 32;
  localparam int SEMN_W = 3;
  localparam int CNT_W = 8;
  localparam int TASK_W = 4;
  localparam int WAKE_W = 31;
  localparam int STAT_W = 2;

  localparam logic [TIME_W-1:0] IDLE_DEADLINE = 32'h7FFF_FFFF;
  localparam logic [TIME_W-1:0] NO_WAKE = 32'h7FFF_FFFF;
  localparam logic [TIME_W-1:0] MAX_TIME = 32'hFFFF_FFFF;

  typedef enum logic [KIND_W-1:0] {
    K_TICK = 3'd0,
    K_CREATE = 3'd1,
    K_SLEEP = 3'd2,
    K_WAIT = 3'd3,
    K_SIGNAL = 3'd4,
    K_TERM = 3'd5,
    K_SEMNEW = 3'd6,
    K_NONE = 3'd7
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    S_OK = 2'd0,
    S_FULL = 2'd1,
    S_BADSEM = 2'd2,
    S_NORUN = 2'd3
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] release_time;
    logic [TIME_W-1:0] deadline_time;
    logic [SEMN_W-1:0] sem_number;
    logic [CNT_W-1:0] sem_initial;
  } event_t;

  typedef struct packed {
    logic [TASK_W-1:0] running_task;
    logic switched;
    logic [WAKE_W-1:0] next_wake;
    logic sem_acquired;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

// ===== design/edfs_if.sv =====
// Valid/ready channel interface carrying one payload.
// Takes its payload type as a parameter; it imports no package.
interface edfs_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== design/edfs_queue.sv =====
// Two-entry queue between the event front end and the scheduler core.
// Depends on edfs_pkg.
module edfs_queue
  import edfs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  event_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output event_t out_data
);
  event_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== design/edfs_core.sv =====
// Scheduler core: task table, semaphores and the per-event scan sequencer.
// Depends on edfs_pkg.
module edfs_core
  import edfs_pkg::*;
#(
  parameter int MAX_TASKS = 8,
  parameter int MAX_SEMS = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  event_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);
  localparam int IDX_W = $clog2(MAX_TASKS + 1);
  localparam int SIDX_W = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;

  typedef enum logic [2:0] {
    ST_TERMINATED = 3'd0,
    ST_READY = 3'd1,
    ST_TIMEWAIT = 3'd2
  } tstate_t;

  typedef enum logic [2:0] {
    IDLE, SIGSCAN, SCAN, DONE
  } fsm_t;

  fsm_t fsm;
  logic [TIME_W-1:0] rel_tab [MAX_TASKS+1];
  logic [TIME_W-1:0] dl_tab [MAX_TASKS+1];
  logic [2:0] st_tab [MAX_TASKS+1];
  logic [CNT_W-1:0] sem_cnt [MAX_SEMS];
  logic [IDX_W-1:0] total, cur, old, idx, best, pick;
  logic [TIME_W-1:0] wake, best_dl, mind, now;
  logic [2:0] sem_code;
  logic [TASK_W-1:0] cur_task;

  logic sem_ok;
  logic [SIDX_W-1:0] sidx;
  logic [2:0] st_i;
  logic [TIME_W-1:0] rel_i, dl_i;
  logic due;
  logic [TIME_W-1:0] wake_base, wake_scan;

  assign sem_ok = (in_data.sem_number != '0) &&
                  ({29'd0, in_data.sem_number} <= 32'(MAX_SEMS));
  assign sidx = SIDX_W'(in_data.sem_number - 3'd1);
  assign in_ready = (fsm == IDLE);
  assign out_valid = (fsm == DONE);
  assign st_i = st_tab[idx];
  assign rel_i = rel_tab[idx];
  assign dl_i = dl_tab[idx];
  assign due = (st_i == ST_TIMEWAIT) && (rel_i <= now);
  assign cur_task = TASK_W'(cur);
  // wake search restarts at the first entry of every scan
  assign wake_base = (idx == IDX_W'(1)) ? NO_WAKE : wake;
  assign wake_scan = (!due && st_i == ST_TIMEWAIT && rel_i < wake_base) ? rel_i : wake_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= IDLE;
      total <= '0;
      cur <= '0;
      wake <= NO_WAKE;
      for (int i = 0; i <= MAX_TASKS; i++) begin
        rel_tab[i] <= '0;
        dl_tab[i] <= (i == 0) ? IDLE_DEADLINE : '0;
        st_tab[i] <= ST_TERMINATED;
      end
      for (int s = 0; s < MAX_SEMS; s++) sem_cnt[s] <= '0;
    end else begin
      unique case (fsm)
        IDLE: if (in_valid) begin
          old <= cur;
          now <= in_data.now_time;
          idx <= IDX_W'(1);
          best <= '0;
          best_dl <= IDLE_DEADLINE;
          pick <= '0;
          mind <= MAX_TIME;
          sem_code <= 3'(2) + in_data.sem_number;
          out_data.sem_acquired <= 1'b0;
          out_data.status <= S_OK;
          out_data.switched <= 1'b0;
          out_data.running_task <= cur_task;
          out_data.next_wake <= wake[WAKE_W-1:0];
          fsm <= DONE;
          unique case (kind_t'(in_data.kind))
            K_TICK: fsm <= SCAN;
            K_CREATE: begin
              if (total >= IDX_W'(MAX_TASKS)) out_data.status <= S_FULL;
              else begin
                total <= total + 1'b1;
                rel_tab[total + 1'b1] <= in_data.release_time;
                dl_tab[total + 1'b1] <= in_data.deadline_time;
                st_tab[total + 1'b1] <= ST_TIMEWAIT;
                fsm <= SCAN;
              end
            end
            K_SLEEP, K_TERM: begin
              if (cur == '0) out_data.status <= S_NORUN;
              else begin
                if (kind_t'(in_data.kind) == K_SLEEP) begin
                  st_tab[cur] <= ST_TIMEWAIT;
                  dl_tab[cur] <= dl_tab[cur] + in_data.deadline_time;
                  rel_tab[cur] <= rel_tab[cur] + in_data.release_time;
                end else st_tab[cur] <= ST_TERMINATED;
                fsm <= SCAN;
              end
            end
            K_WAIT: begin
              if (!sem_ok) out_data.status <= S_BADSEM;
              else if (cur == '0) out_data.status <= S_NORUN;
              else if (sem_cnt[sidx] != '0) begin
                sem_cnt[sidx] <= sem_cnt[sidx] - 1'b1;
                out_data.sem_acquired <= 1'b1;
              end else begin
                st_tab[cur] <= 3'(2) + in_data.sem_number;
                fsm <= SCAN;
              end
            end
            K_SIGNAL: begin
              if (!sem_ok) out_data.status <= S_BADSEM;
              else fsm <= SIGSCAN;
            end
            K_SEMNEW: begin
              if (!sem_ok) out_data.status <= S_BADSEM;
              else sem_cnt[sidx] <= in_data.sem_initial;
            end
            default: ;
          endcase
        end
        SIGSCAN: begin
          // one table entry per cycle; later index wins on equal deadline
          if (idx > total || idx > IDX_W'(MAX_TASKS)) begin
            idx <= IDX_W'(1);
            if (pick == '0) begin
              if (sem_cnt[SIDX_W'(sem_code - 3'd3)] != 8'hFF)
                sem_cnt[SIDX_W'(sem_code - 3'd3)] <=
                  sem_cnt[SIDX_W'(sem_code - 3'd3)] + 1'b1;
              fsm <= DONE;
            end else begin
              st_tab[pick] <= ST_READY;
              fsm <= SCAN;
            end
          end else begin
            if (st_i == sem_code && dl_i <= mind) begin
              pick <= idx;
              mind <= dl_i;
            end
            idx <= idx + 1'b1;
          end
        end
        SCAN: begin
          if (idx > total || idx > IDX_W'(MAX_TASKS)) begin
            cur <= best;
            wake <= wake_base;
            out_data.running_task <= TASK_W'(best);
            out_data.switched <= (best != old);
            out_data.next_wake <= wake_base[WAKE_W-1:0];
            fsm <= DONE;
          end else begin
            if (due) st_tab[idx] <= ST_READY;
            wake <= wake_scan;
            if ((due || st_i == ST_READY) && dl_i < best_dl) begin
              best <= idx;
              best_dl <= dl_i;
            end
            idx <= idx + 1'b1;
          end
        end
        DONE: if (out_ready) fsm <= IDLE;
        default: fsm <= IDLE;
      endcase
    end
  end
endmodule

// ===== design/edf_task_scheduler.sv =====
// EDF task scheduler top level: front queue plus scheduler core.
// Depends on edfs_pkg, edfs_if, edfs_queue, edfs_core.
//
// One event in, one result out. The time from an event to its result is set by
// the table scan, which visits one task entry per cycle: an event that neither
// rescans nor signals skips the scan, a reschedule or a signal that only bumps a
// count scans the table once, and a signal that wakes a waiter scans it twice.
// After its result is taken, the core returns to idle before it takes the next
// event. A two-entry queue takes new events while the core works; the result
// register holds until taken.
module edf_task_scheduler
  import edfs_pkg::*;
#(
  parameter int MAX_TASKS = 8,
  parameter int MAX_SEMS = 4
) (
  input logic clk,
  input logic rst,
  edfs_if.sink ev,
  edfs_if.source res
);
  logic q_valid, q_ready;
  event_t q_data;

  edfs_queue u_queue (
    .clk, .rst,
    .in_valid(ev.valid), .in_ready(ev.ready), .in_data(ev.data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  edfs_core #(.MAX_TASKS(MAX_TASKS), .MAX_SEMS(MAX_SEMS)) u_core (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(res.valid), .out_ready(res.ready), .out_data(res.data)
  );
endmodule

// ===== design/edfs_checker.sv =====
// Port-level checks for the EDF task scheduler, bound to the top level.
// Depends on edfs_pkg and edf_task_scheduler.
module edfs_checker
  import edfs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic ev_ready,
  input logic res_valid,
  input logic res_ready,
  input result_t res_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result dropped while stalled");
  a_acq: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.sem_acquired |-> !res_data.switched &&
      res_data.status == S_OK)
    else $error("acquire with switch");
  a_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != S_OK |-> !res_data.switched)
    else $error("rejected event switched task");
  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result after reset");
  a_rdy: assert property (@(posedge clk) rst |=> ev_ready)
    else $error("input not ready after reset");
endmodule

bind edf_task_scheduler edfs_checker u_chk (
  .clk(clk), .rst(rst),
  .ev_ready(ev.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);

// ===== sim/tb_top.sv =====
// Testbench for the EDF task scheduler: random and directed events, scoreboard check.
// Depends on edfs_pkg, edfs_if and the edf_task_scheduler RTL.
module tb_top;
  import edfs_pkg::*;

  localparam int NTASK = 8;
  localparam int NSEM = 4;
  localparam logic [2:0] TS_DEAD = 3'd0;
  localparam logic [2:0] TS_READY = 3'd1;
  localparam logic [2:0] TS_TWAIT = 3'd2;

  class sched_board;
    logic [31:0] rel_tab [0:NTASK];
    logic [31:0] dl_tab [0:NTASK];
    logic [2:0] st_tab [0:NTASK];
    int unsigned ntask;
    int unsigned cur;
    logic [7:0] sem_cnt [0:NSEM-1];
    logic [31:0] wake;
    result_t pending[$];
    int errors;

    function new();
      for (int i = 0; i <= NTASK; i++) begin
        rel_tab[i] = '0;
        dl_tab[i] = '0;
        st_tab[i] = TS_DEAD;
      end
      dl_tab[0] = IDLE_DEADLINE;
      ntask = 0;
      cur = 0;
      for (int i = 0; i < NSEM; i++) sem_cnt[i] = '0;
      wake = NO_WAKE;
      errors = 0;
    endfunction

    function void pick_edf(logic [31:0] now);
      int unsigned best;
      logic [31:0] w;
      best = 0;
      w = NO_WAKE;
      for (int i = 1; i <= ntask; i++) begin
        if (st_tab[i] == TS_TWAIT) begin
          if (rel_tab[i] <= now) st_tab[i] = TS_READY;
          else if (rel_tab[i] < w) w = rel_tab[i];
        end
        if (st_tab[i] == TS_READY && dl_tab[i] < dl_tab[best]) best = i;
      end
      cur = best;
      wake = w;
    endfunction

    function void note_event(event_t e);
      int unsigned prev, pick;
      logic [31:0] mind;
      status_t st;
      bit acq, resched, sem_good;
      result_t r;
      prev = cur;
      st = S_OK;
      acq = 0;
      resched = 0;
      sem_good = e.sem_number >= 1 && e.sem_number <= NSEM;
      case (kind_t'(e.kind))
        K_TICK: resched = 1;
        K_CREATE: begin
          if (ntask >= NTASK) st = S_FULL;
          else begin
            ntask++;
            rel_tab[ntask] = e.release_time;
            dl_tab[ntask] = e.deadline_time;
            st_tab[ntask] = TS_TWAIT;
            resched = 1;
          end
        end
        K_SLEEP: begin
          if (cur == 0) st = S_NORUN;
          else begin
            st_tab[cur] = TS_TWAIT;
            dl_tab[cur] += e.deadline_time;
            rel_tab[cur] += e.release_time;
            resched = 1;
          end
        end
        K_WAIT: begin
          if (!sem_good) st = S_BADSEM;
          else if (cur == 0) st = S_NORUN;
          else if (sem_cnt[e.sem_number-1] > 0) begin
            sem_cnt[e.sem_number-1]--;
            acq = 1;
          end else begin
            st_tab[cur] = TS_TWAIT + e.sem_number;
            resched = 1;
          end
        end
        K_SIGNAL: begin
          if (!sem_good) st = S_BADSEM;
          else begin
            pick = 0;
            mind = MAX_TIME;
            for (int i = 1; i <= ntask; i++)
              if (st_tab[i] == TS_TWAIT + e.sem_number && dl_tab[i] <= mind) begin
                pick = i;
                mind = dl_tab[i];
              end
            if (pick == 0) begin
              if (sem_cnt[e.sem_number-1] != 8'hFF) sem_cnt[e.sem_number-1]++;
            end else begin
              st_tab[pick] = TS_READY;
              resched = 1;
            end
          end
        end
        K_TERM: begin
          if (cur == 0) st = S_NORUN;
          else begin
            st_tab[cur] = TS_DEAD;
            resched = 1;
          end
        end
        K_SEMNEW: begin
          if (!sem_good) st = S_BADSEM;
          else sem_cnt[e.sem_number-1] = e.sem_initial;
        end
        default: ;
      endcase
      if (resched) pick_edf(e.now_time);
      r.running_task = cur[3:0];
      r.switched = cur != prev;
      r.next_wake = wake[30:0];
      r.sem_acquired = acq;
      r.status = st;
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.running_task !== want.running_task || got.switched !== want.switched ||
          got.next_wake !== want.next_wake || got.sem_acquired !== want.sem_acquired ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #1 clk = ~clk;

  edfs_if #(.payload_t(event_t)) ev (clk);
  edfs_if #(.payload_t(result_t)) res (clk);

  edf_task_scheduler DUT (.clk(clk), .rst(rst), .ev(ev), .res(res));

  sched_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  logic [31:0] clock_now = 0;

  initial begin
    ev.valid = 0;
    ev.data = '0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready) board.check_result(res.data);
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // valid stays high after acceptance; the next idle cycle or drain drops it
  task automatic send_event(event_t e);
    while ($urandom_range(99) < idle_pct) begin
      ev.valid <= 0;
      @(posedge clk);
    end
    ev.valid <= 1;
    ev.data <= e;
    @(posedge clk);
    while (!ev.ready) @(posedge clk);
    board.note_event(e);
  endtask

  function automatic event_t make_event(kind_t k, logic [31:0] now, logic [31:0] rel,
                                        logic [31:0] dl, logic [2:0] s, logic [7:0] ini);
    event_t e;
    e.kind = k;
    e.now_time = now;
    e.release_time = rel;
    e.deadline_time = dl;
    e.sem_number = s;
    e.sem_initial = ini;
    return e;
  endfunction

  // Mostly well-formed scheduler traffic with a monotonic clock and valid semaphores.
  function automatic event_t random_event();
    event_t e;
    int unsigned r;
    logic [127:0] raw;
    r = $urandom_range(99);
    if (r < 3) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      e = raw[$bits(event_t)-1:0];
      return e;
    end
    clock_now += $urandom_range(40);
    e = make_event(K_TICK, clock_now, 0, 0, 3'($urandom_range(1, NSEM)), 8'($urandom));
    if (r < 8) e.sem_number = 3'($urandom_range(7));
    if (r < 25) e.kind = K_TICK;
    else if (r < 37) begin
      e.kind = K_CREATE;
      e.release_time = clock_now + $urandom_range(60);
      e.deadline_time = e.release_time + $urandom_range(200);
      if ($urandom_range(9) == 0) e.deadline_time = $urandom;
    end else if (r < 52) begin
      e.kind = K_SLEEP;
      e.release_time = $urandom_range(60);
      e.deadline_time = $urandom_range(200);
      if ($urandom_range(19) == 0) begin
        e.release_time = $urandom;
        e.deadline_time = $urandom;
      end
    end else if (r < 66) e.kind = K_WAIT;
    else if (r < 82) e.kind = K_SIGNAL;
    else if (r < 90) e.kind = K_TERM;
    else if (r < 98) begin
      e.kind = K_SEMNEW;
      e.sem_initial = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(3));
    end else e.kind = K_NONE;
    return e;
  endfunction

  task automatic drain();
    ev.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: no running task, bad semaphores, saturation, table full, ties, wrap
    send_event(make_event(K_SLEEP, 0, 1, 1, 1, 0));
    send_event(make_event(K_WAIT, 0, 0, 0, 0, 0));
    send_event(make_event(K_WAIT, 0, 0, 0, 1, 0));
    send_event(make_event(K_TERM, 0, 0, 0, 1, 0));
    send_event(make_event(K_SEMNEW, 0, 0, 0, 5, 8'hFF));
    send_event(make_event(K_SEMNEW, 0, 0, 0, 4, 8'hFE));
    send_event(make_event(K_SIGNAL, 0, 0, 0, 4, 0));
    send_event(make_event(K_SIGNAL, 0, 0, 0, 4, 0));
    send_event(make_event(K_NONE, MAX_TIME, MAX_TIME, MAX_TIME, 7, 8'hFF));
    send_event(make_event(K_CREATE, 0, 10, 50, 1, 0));
    send_event(make_event(K_CREATE, 5, 3, 50, 1, 0));
    send_event(make_event(K_CREATE, 20, 20, 50, 1, 0));
    for (int i = 0; i < 6; i++) send_event(make_event(K_CREATE, 20, 30 + i, MAX_TIME, 1, 0));
    send_event(make_event(K_TICK, 25, 0, 0, 1, 0));
    send_event(make_event(K_WAIT, 25, 0, 0, 2, 0));
    send_event(make_event(K_WAIT, 25, 0, 0, 2, 0));
    send_event(make_event(K_SIGNAL, 25, 0, 0, 2, 0));
    send_event(make_event(K_SLEEP, 26, MAX_TIME, MAX_TIME, 1, 0));
    send_event(make_event(K_TERM, 40, 0, 0, 1, 0));
    send_event(make_event(K_TICK, MAX_TIME, 0, 0, 1, 0));
    drain();

    // four phases of idle and stall mixes; the reset table never refills, so random work stays tasks-filled
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 71 : 27) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 71 : 27) : 0;
      for (int n = 0; n < 460; n++) begin
        if (n % 100 == 50) send_event(make_event(K_SEMNEW, clock_now, 0, 0, 1, 0));
        send_event(random_event());
        if (n == 200) drain();
      end
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();
    if (board.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
design/edfs_pkg.sv
design/edfs_if.sv
design/edfs_queue.sv
design/edfs_core.sv
design/edf_task_scheduler.sv
design/edfs_checker.sv
sim/tb_top.sv
